// ===== rtl/rect_fill_outline_span_generator_unit_macros.svh =====
// Assertion macros shared by the span generator modules.
`ifndef RECT_FILL_OUTLINE_SPAN_GENERATOR_UNIT_MACROS_SVH
`define RECT_FILL_OUTLINE_SPAN_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define RFOSG_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define RFOSG_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/rfosg_pkg.sv =====
// Package with shared types and constants of the rectangle span generator.
`timescale 1ns / 1ps
`default_nettype none

package rfosg_pkg;

  localparam int FrameWidthDefault  = 80;
  localparam int FrameHeightDefault = 25;
  localparam int MaxSpans           = 50;
  localparam int CntW               = $clog2(MaxSpans + 1);

  localparam logic OpFill    = 1'b0;
  localparam logic OpOutline = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_CLIP,
    ST_SETUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clip;
    logic setup;
    logic active;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last_span;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/rfosg_datapath.sv =====
// Datapath: clamps and clips the request, then walks rows and forms spans.
`timescale 1ns / 1ps
`default_nettype none

`include "rect_fill_outline_span_generator_unit_macros.svh"

module rfosg_datapath #(
  parameter int FRAME_WIDTH  = rfosg_pkg::FrameWidthDefault,
  parameter int FRAME_HEIGHT = rfosg_pkg::FrameHeightDefault
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire rfosg_pkg::cmd_t    cmd,
  output rfosg_pkg::sts_t         sts,
  input  wire                     opcode,
  input  wire signed [8:0]        pos_x,
  input  wire signed [6:0]        pos_y,
  input  wire [7:0]               rect_width,
  input  wire [5:0]               rect_height,
  input  wire [7:0]               color,
  input  wire [5:0]               thickness,
  output logic [10:0]             span_address,
  output logic [6:0]              span_length,
  output logic [7:0]              span_color,
  output logic                    last
);

  localparam int XW = $clog2(FRAME_WIDTH + 1);
  localparam int YW = $clog2(FRAME_HEIGHT + 1);

  logic                     op_q;
  logic [XW-1:0]            x_q;
  logic [YW-1:0]            y_q;
  logic [7:0]               w_q;
  logic [5:0]               h_q;
  logic [5:0]               t_q;
  logic [7:0]               color_q;
  logic [10:0]              base_q;
  logic [5:0]               row_q;
  logic                     right_q;
  logic [rfosg_pkg::CntW-1:0] cnt_q;
  logic                     wide_q;
  logic [7:0]               roff_q;

  logic [XW-1:0]            x_next;
  logic [YW-1:0]            y_next;
  logic [7:0]               avail_w;
  logic [6:0]               avail_h;
  logic                     full;
  logic                     last_row;

  // Clamp the signed position into the frame.
  always_comb begin
    if (pos_x[8]) begin
      x_next = '0;
    end else if (pos_x[7:0] > 8'(FRAME_WIDTH - 1)) begin
      x_next = XW'(FRAME_WIDTH - 1);
    end else begin
      x_next = XW'(pos_x[7:0]);
    end
    if (pos_y[6]) begin
      y_next = '0;
    end else if (pos_y[5:0] > 6'(FRAME_HEIGHT - 1)) begin
      y_next = YW'(FRAME_HEIGHT - 1);
    end else begin
      y_next = YW'(pos_y[5:0]);
    end
  end

  assign avail_w = 8'(FRAME_WIDTH) - 8'(x_q);
  assign avail_h = 7'(FRAME_HEIGHT) - 7'(y_q);

  // A row is one full span unless it is an inner row of an outline wider than twice its thickness.
  assign full = (op_q == rfosg_pkg::OpFill) || (row_q < t_q) ||
                ((7'(row_q) + 7'(t_q)) >= 7'(h_q)) || wide_q;
  assign last_row = (row_q == (h_q - 6'd1));

  assign sts.empty     = (w_q == 8'd0) || (h_q == 6'd0);
  assign sts.last_span = (last_row && (full || right_q)) ||
                         (cnt_q == rfosg_pkg::CntW'(rfosg_pkg::MaxSpans - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= opcode;
      x_q     <= x_next;
      y_q     <= y_next;
      w_q     <= rect_width;
      h_q     <= rect_height;
      t_q     <= (thickness == 6'd0) ? 6'd1 : thickness;
      color_q <= color;
    end
    if (cmd.clip) begin
      if (w_q > avail_w) begin
        w_q <= avail_w;
      end
      if ({1'b0, h_q} > avail_h) begin
        h_q <= 6'(avail_h);
      end
      // Address arithmetic wraps at the field width.
      base_q <= (11'(y_q) * 11'(FRAME_WIDTH)) + 11'(x_q);
    end
    if (cmd.setup) begin
      wide_q  <= ({2'b00, t_q} << 1) >= w_q;
      roff_q  <= w_q - {2'b00, t_q};
      row_q   <= '0;
      right_q <= 1'b0;
      cnt_q   <= '0;
    end
    if (cmd.step) begin
      cnt_q <= cnt_q + rfosg_pkg::CntW'(1);
      if (!full && !right_q) begin
        right_q <= 1'b1;
      end else begin
        right_q <= 1'b0;
        row_q   <= row_q + 6'd1;
        base_q  <= base_q + 11'(FRAME_WIDTH);
      end
    end
  end

  always_comb begin
    span_color = color_q;
    last       = sts.last_span;
    if (full) begin
      span_address = base_q;
      span_length  = 7'(w_q);
    end else if (right_q) begin
      span_address = base_q + 11'(roff_q);
      span_length  = 7'(t_q);
    end else begin
      span_address = base_q;
      span_length  = 7'(t_q);
    end
  end

  `RFOSG_ASSERT_IMP(a_cnt_bound, cmd.active,
                    cnt_q < rfosg_pkg::CntW'(rfosg_pkg::MaxSpans), "span count overrun")
  `RFOSG_ASSERT_IMP(a_right_split, cmd.active && right_q, !full,
                    "right span on a full row")
  `RFOSG_ASSERT_IMP(a_row_bound, cmd.active, row_q < h_q, "row walked past height")

endmodule

`default_nettype wire

// ===== rtl/rfosg_ctrl.sv =====
// Controller state machine that sequences setup and span emission.
`timescale 1ns / 1ps
`default_nettype none

`include "rect_fill_outline_span_generator_unit_macros.svh"

module rfosg_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  output rfosg_pkg::cmd_t      cmd,
  input  wire rfosg_pkg::sts_t sts
);

  rfosg_pkg::state_t state;
  rfosg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfosg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rfosg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = rfosg_pkg::ST_CLAMP;
        end
      end
      rfosg_pkg::ST_CLAMP: state_next = rfosg_pkg::ST_CLIP;
      rfosg_pkg::ST_CLIP:  state_next = rfosg_pkg::ST_SETUP;
      rfosg_pkg::ST_SETUP: begin
        state_next = sts.empty ? rfosg_pkg::ST_IDLE : rfosg_pkg::ST_EMIT;
      end
      rfosg_pkg::ST_EMIT: begin
        if (!out_stall && sts.last_span) begin
          state_next = rfosg_pkg::ST_IDLE;
        end
      end
      default: state_next = rfosg_pkg::ST_IDLE;
    endcase
  end

  // The datapath registers the position in the request cycle; the width
  // and height clip in ST_CLIP, after ST_CLAMP, once the clamped corner is known.
  always_comb begin
    in_stall   = (state != rfosg_pkg::ST_IDLE);
    out_valid  = (state == rfosg_pkg::ST_EMIT);
    cmd.load   = (state == rfosg_pkg::ST_IDLE) && in_valid;
    cmd.clip   = (state == rfosg_pkg::ST_CLIP);
    cmd.setup  = (state == rfosg_pkg::ST_SETUP);
    cmd.active = (state == rfosg_pkg::ST_EMIT);
    cmd.step   = (state == rfosg_pkg::ST_EMIT) && !out_stall;
  end

  `RFOSG_ASSERT_NXT(a_last_to_idle, out_valid && !out_stall && sts.last_span,
                    state == rfosg_pkg::ST_IDLE, "no return to idle after last span")
  `RFOSG_ASSERT_NXT(a_accept_starts, in_valid && !in_stall,
                    state == rfosg_pkg::ST_CLAMP, "accepted request did not start")
  `RFOSG_ASSERT_NXT(a_setup_emits, state == rfosg_pkg::ST_SETUP && !sts.empty,
                    out_valid, "non-empty request produced no span")

endmodule

`default_nettype wire

// ===== rtl/rect_fill_outline_span_generator_unit.sv =====
// Top level of the rectangle fill and outline span generator.
`timescale 1ns / 1ps
`default_nettype none

// Takes one draw request at a time for a FRAME_WIDTH by FRAME_HEIGHT
// character frame and emits row spans (address, length, color) from the top
// row down, left span before right span, with last set on the final one.
// A request goes through setup (accept, clamp, clip and setup steps), then
// one span per cycle while out_stall is low: a filled rectangle gives one span
// per row, an outline up to two per row, at most 50 spans in all. An empty
// rectangle returns to idle after the setup step with no span. The span
// sequencer in the controller sets the rate, and in_stall stays high from
// acceptance until the last span is taken, or until setup ends if empty.
module rect_fill_outline_span_generator_unit #(
  parameter int FRAME_WIDTH  = rfosg_pkg::FrameWidthDefault,
  parameter int FRAME_HEIGHT = rfosg_pkg::FrameHeightDefault
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               opcode,
  input  wire signed [8:0]  pos_x,
  input  wire signed [6:0]  pos_y,
  input  wire [7:0]         rect_width,
  input  wire [5:0]         rect_height,
  input  wire [7:0]         color,
  input  wire [5:0]         thickness,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [10:0]       span_address,
  output logic [6:0]        span_length,
  output logic [7:0]        span_color,
  output logic              last
);

  rfosg_pkg::cmd_t cmd;
  rfosg_pkg::sts_t sts;

  rfosg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rfosg_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .color        (color),
    .thickness    (thickness),
    .span_address (span_address),
    .span_length  (span_length),
    .span_color   (span_color),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the rectangle fill and outline span generator.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAME_W = 80;
  localparam int FRAME_H = 25;

  typedef struct {
    logic              op;
    logic signed [8:0] x;
    logic signed [6:0] y;
    logic [7:0]        w;
    logic [5:0]        h;
    logic [7:0]        col;
    logic [5:0]        thick;
  } draw_cmd_t;

  typedef struct {
    logic [10:0] addr;
    logic [6:0]  len;
    logic [7:0]  col;
    logic        last;
  } span_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              opcode = 1'b0;
  logic signed [8:0] pos_x = '0;
  logic signed [6:0] pos_y = '0;
  logic [7:0]        rect_width = '0;
  logic [5:0]        rect_height = '0;
  logic [7:0]        color = '0;
  logic [5:0]        thickness = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [10:0]       span_address;
  logic [6:0]        span_length;
  logic [7:0]        span_color;
  logic              last;

  span_t expected_spans[$];
  int    fail_count = 0;
  bit    idle_on = 1'b1;
  bit    hold_req = 1'b0;
  int    hold_cycles = 0;

  rect_fill_outline_span_generator_unit #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .color       (color),
    .thickness   (thickness),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .span_address(span_address),
    .span_length (span_length),
    .span_color  (span_color),
    .last        (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void add_span(ref int n, input int addr, input int len,
                                   input logic [7:0] col);
    span_t s;
    if (n < rfosg_pkg::MaxSpans) begin
      s.addr = addr[10:0];
      s.len  = len[6:0];
      s.col  = col;
      s.last = 1'b0;
      expected_spans.push_back(s);
      n++;
    end
  endfunction

  // Clamp the corner into the frame, clip the size to the frame edge, then
  // walk the rows from the top down.
  function automatic void predict_spans(draw_cmd_t c);
    int  cx, cy, w, h, t, row, n, base;
    bit  full;
    n  = 0;
    cx = c.x;
    cy = c.y;
    if (cx < 0) cx = 0;
    if (cx > FRAME_W - 1) cx = FRAME_W - 1;
    if (cy < 0) cy = 0;
    if (cy > FRAME_H - 1) cy = FRAME_H - 1;
    w = c.w;
    h = c.h;
    t = c.thick;
    if (w > FRAME_W - cx) w = FRAME_W - cx;
    if (h > FRAME_H - cy) h = FRAME_H - cy;
    if (w <= 0 || h <= 0) return;
    if (t == 0) t = 1;
    for (row = 0; row < h; row++) begin
      base = (cy + row) * FRAME_W + cx;
      full = (c.op == rfosg_pkg::OpFill) || row < t || row >= h - t || 2 * t >= w;
      if (full) begin
        add_span(n, base, w, c.col);
      end else begin
        add_span(n, base, t, c.col);
        add_span(n, base + w - t, t, c.col);
      end
    end
    if (n > 0) expected_spans[$].last = 1'b1;
  endfunction

  function automatic draw_cmd_t make_cmd(logic op, int x, int y, int w, int h,
                                         int col, int t);
    draw_cmd_t c;
    c.op    = op;
    c.x     = 9'(x);
    c.y     = 7'(y);
    c.w     = 8'(w);
    c.h     = 6'(h);
    c.col   = 8'(col);
    c.thick = 6'(t);
    return c;
  endfunction

  // Most requests sit inside the frame with small sizes; the rest use the
  // full range of position and size to reach clamping and clipping.
  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    int        kind;
    kind    = $urandom_range(0, 9);
    c.op    = 1'($urandom_range(0, 1));
    c.col   = 8'($urandom_range(0, 255));
    c.thick = (kind < 7) ? 6'($urandom_range(0, 4)) : 6'($urandom_range(0, 63));
    if (kind < 6) begin
      c.x = 9'($urandom_range(0, FRAME_W - 1));
      c.y = 7'($urandom_range(0, FRAME_H - 1));
      c.w = 8'($urandom_range(1, 40));
      c.h = 6'($urandom_range(1, 12));
    end else begin
      c.x = 9'($urandom_range(0, 511));
      c.y = 7'($urandom_range(0, 127));
      c.w = 8'($urandom_range(0, 255));
      c.h = 6'($urandom_range(0, 63));
    end
    return c;
  endfunction

  task automatic send_cmd(draw_cmd_t c);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= c.op;
    pos_x       <= c.x;
    pos_y       <= c.y;
    rect_width  <= c.w;
    rect_height <= c.h;
    color       <= c.col;
    thickness   <= c.thick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_spans(c);
  endtask

  // Receiver side: random short stalls, or one long counted hold on request.
  initial begin : receiver
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 1; n < hold_cycles; n++) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    span_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_spans.size() == 0) begin
        note_failure($sformatf("unexpected span addr=%0d len=%0d color=%0d last=%0b",
                               span_address, span_length, span_color, last));
      end else begin
        want = expected_spans.pop_front();
        if (span_address !== want.addr || span_length !== want.len ||
            span_color !== want.col || last !== want.last) begin
          note_failure($sformatf(
              "expected addr=%0d len=%0d color=%0d last=%0b, got addr=%0d len=%0d color=%0d last=%0b",
              want.addr, want.len, want.col, want.last,
              span_address, span_length, span_color, last));
        end
      end
    end
  end

  task automatic test_clamp_and_clip();
    send_cmd(make_cmd(rfosg_pkg::OpFill, 0, 0, 255, 63, 8'hFF, 0));
    send_cmd(make_cmd(rfosg_pkg::OpFill, -256, -64, 3, 2, 8'h00, 0));
    send_cmd(make_cmd(rfosg_pkg::OpFill, 255, 63, 255, 63, 8'h5A, 63));
    send_cmd(make_cmd(rfosg_pkg::OpFill, 79, 0, 255, 1, 8'hA5, 0));
    send_cmd(make_cmd(rfosg_pkg::OpFill, 70, 20, 40, 10, 8'h3C, 0));
  endtask

  task automatic test_empty();
    send_cmd(make_cmd(rfosg_pkg::OpFill, 10, 10, 0, 5, 8'h11, 0));
    send_cmd(make_cmd(rfosg_pkg::OpFill, 10, 10, 5, 0, 8'h22, 0));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 0, 0, 0, 5, 8'h33, 2));
  endtask

  task automatic test_outline_bands();
    // Thickness zero acts as one: the full frame gives the most spans.
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 0, 0, 255, 63, 8'hC3, 0));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 10, 5, 20, 8, 8'h01, 1));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 5, 3, 6, 9, 8'h80, 3));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 0, 0, 80, 25, 8'h7E, 63));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 30, 2, 5, 10, 8'h44, 2));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 40, 10, 30, 6, 8'h55, 5));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 75, 22, 30, 30, 8'h66, 1));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, -1, -1, 1, 1, 8'h77, 0));
  endtask

  // The receiver holds off while further requests are offered, so the block
  // fills up and stalls its input.
  task automatic test_output_hold();
    hold_cycles = 150;
    hold_req    = 1'b1;
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 0, 0, 255, 63, 8'h9A, 1));
    send_cmd(make_cmd(rfosg_pkg::OpFill, 20, 4, 10, 3, 8'h9B, 0));
    send_cmd(make_cmd(rfosg_pkg::OpOutline, 3, 3, 12, 7, 8'h9C, 2));
    send_cmd(make_cmd(rfosg_pkg::OpFill, 60, 24, 30, 9, 8'h9D, 0));
    send_cmd(make_cmd(rfosg_pkg::OpFill, 0, 0, 1, 1, 8'h9E, 0));
  endtask

  task automatic test_random_commands(int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == count - 60) idle_on = 1'b0;
      send_cmd(rand_cmd());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_clamp_and_clip();
    test_empty();
    test_outline_bands();
    test_output_hold();
    test_random_commands(310);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_spans.size() != 0) begin
      note_failure($sformatf("%0d spans never arrived", expected_spans.size()));
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
